// ===== hdl/lzfd_pkg.sv =====
// Package for the LZF decompressor: parse codes, controller states, command and
// status structs and default sizes. Depends on nothing.
package lzfd_pkg;

  localparam int HISTORY_DEPTH_DEF = 8192;
  localparam int OUT_LANES_DEF     = 8;

  localparam int DIST_W  = 13;  // back-reference distance
  localparam int LEN_W   = 9;   // back-reference length
  localparam int RUN_W   = 6;   // literal run counters
  localparam int CNT_W   = 4;   // byte_count field
  localparam int WORD_W  = 64;  // out_bytes field

  localparam logic [2:0]       CTRL_LONG   = 3'b111;
  localparam logic [7:0]       LIT_LIMIT   = 8'd32;
  localparam logic [RUN_W-1:0] RUN_FULL    = RUN_W'(32);
  localparam logic [LEN_W-1:0] LEN_LONG    = LEN_W'(7);
  localparam logic [LEN_W-1:0] LEN_BIAS    = LEN_W'(2);

  typedef enum logic [2:0] {
    PS_START    = 3'd0,
    PS_LITERAL  = 3'd1,
    PS_CONTROL  = 3'd2,
    PS_EXTEND   = 3'd3,
    PS_DISTANCE = 3'd4
  } parse_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DECODE,
    C_COPY_RD,
    C_COPY_WR,
    C_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;  // capture the incoming item
    logic decode;   // parse the held byte
    logic rd;       // read one history byte
    logic wr;       // append the read byte to history and lane word
    logic emit;     // move the lane word to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic copy_go;    // held byte completes a valid back reference
    logic lane_done;  // byte being appended fills the word or ends the copy
    logic copy_end;   // no copy bytes left
  } dp_stat_t;

endpackage

// ===== hdl/lzfd_ctrl.sv =====
// Controller state machine of the LZF decompressor.
// Depends on lzfd_pkg.
module lzfd_ctrl
  import lzfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = C_DECODE;
        end
      end
      C_DECODE: begin
        // hold until a result slot is free, so literals and errors can land
        if (stat.out_free) begin
          cmd.decode = 1'b1;
          state_next = stat.copy_go ? C_COPY_RD : C_IDLE;
        end
      end
      C_COPY_RD: begin
        cmd.rd     = 1'b1;
        state_next = C_COPY_WR;
      end
      C_COPY_WR: begin
        cmd.wr     = 1'b1;
        state_next = stat.lane_done ? C_EMIT : C_COPY_RD;
      end
      C_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.copy_end ? C_IDLE : C_COPY_RD;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

endmodule

// ===== hdl/lzfd_datapath.sv =====
// Datapath of the LZF decompressor: input hold, parse registers, history memory,
// copy engine and output register. Depends on lzfd_pkg.
module lzfd_datapath
  import lzfd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int OUT_LANES     = OUT_LANES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [7:0]        in_byte,
  input  logic              stream_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_bytes,
  output logic [CNT_W-1:0]  byte_count,
  output logic              last,
  output logic              error
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int PW     = $clog2(HISTORY_DEPTH + 1);
  localparam int LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

  logic [7:0] hist [HISTORY_DEPTH];

  logic [7:0]       hold_byte;
  logic             hold_start;
  parse_t           ps, ps_next, ps_eff;
  logic [RUN_W-1:0] lit_rem, lit_rem_next, lit_rem_eff, lit_rem_dec;
  logic [RUN_W-1:0] lit_total, lit_total_next, lit_total_eff;
  logic [LEN_W-1:0] mlen, mlen_next, mlen_eff;
  logic [DIST_W-1:0] mdist, mdist_next, mdist_eff, dist_full;
  logic [PW-1:0]    produced, produced_next, produced_eff;
  logic [AW-1:0]    wp, wp_inc;
  logic             ref_err;

  logic [LEN_W-1:0]  cpy_left;
  logic [DIST_W-1:0] cpy_dist;
  logic [7:0]        rd_data;
  logic [AW:0]       src_diff;
  logic [AW-1:0]     src_addr;
  logic [WORD_W-1:0] lane_word;
  logic [CNT_W-1:0]  lane_cnt;

  logic              lit_write;
  logic              append;
  logic [7:0]        wr_byte;

  logic              out_load;
  logic [WORD_W-1:0] out_word_next;
  logic [CNT_W-1:0]  out_cnt_next;
  logic              out_last_next, out_err_next;

  // stream start wipes parse state and produced count ahead of this byte
  always_comb begin
    ps_eff        = hold_start ? PS_START : ps;
    lit_rem_eff   = hold_start ? '0 : lit_rem;
    lit_total_eff = hold_start ? '0 : lit_total;
    mlen_eff      = hold_start ? '0 : mlen;
    mdist_eff     = hold_start ? '0 : mdist;
    produced_eff  = hold_start ? '0 : produced;
    lit_rem_dec   = (lit_rem_eff != '0) ? lit_rem_eff - RUN_W'(1) : '0;
    dist_full     = {mdist_eff[4:0], hold_byte};
    ref_err       = produced_eff < (PW'(dist_full) + PW'(1));
  end

  // parse step
  always_comb begin
    ps_next        = ps_eff;
    lit_rem_next   = lit_rem_eff;
    lit_total_next = lit_total_eff;
    mlen_next      = mlen_eff;
    mdist_next     = mdist_eff;
    lit_write      = 1'b0;
    unique case (ps_eff)
      PS_LITERAL: begin
        lit_write    = 1'b1;
        lit_rem_next = lit_rem_dec;
        if (lit_rem_dec == '0) begin
          if (lit_total_eff == RUN_FULL) begin
            ps_next        = PS_START;
            lit_rem_next   = '0;
            lit_total_next = '0;
            mlen_next      = '0;
            mdist_next     = '0;
          end else begin
            ps_next        = PS_CONTROL;
            lit_total_next = '0;
          end
        end
      end
      PS_EXTEND: begin
        mlen_next = mlen_eff + LEN_W'(hold_byte) + LEN_BIAS;
        ps_next   = PS_DISTANCE;
      end
      PS_DISTANCE: begin
        ps_next        = PS_START;
        lit_rem_next   = '0;
        lit_total_next = '0;
        mlen_next      = '0;
        mdist_next     = '0;
      end
      default: begin
        if (ps_eff != PS_CONTROL && hold_byte < LIT_LIMIT) begin
          lit_total_next = RUN_W'(hold_byte) + RUN_W'(1);
          lit_rem_next   = RUN_W'(hold_byte) + RUN_W'(1);
          ps_next        = PS_LITERAL;
        end else begin
          mdist_next = DIST_W'(hold_byte[4:0]);
          if (hold_byte[7:5] == CTRL_LONG) begin
            mlen_next = LEN_LONG;
            ps_next   = PS_EXTEND;
          end else begin
            mlen_next = LEN_W'(hold_byte[7:5]) + LEN_BIAS;
            ps_next   = PS_DISTANCE;
          end
        end
      end
    endcase
  end

  // history append: a literal on decode or a copied byte
  assign append  = (cmd.decode && lit_write) || cmd.wr;
  assign wr_byte = cmd.wr ? rd_data : hold_byte;
  assign wp_inc  = (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + AW'(1);

  always_comb begin
    produced_next = cmd.decode ? produced_eff : produced;
    if (append && produced_next != PW'(HISTORY_DEPTH)) begin
      produced_next = produced_next + PW'(1);
    end
  end

  // copy source: write pointer minus distance minus one, wrapped once
  always_comb begin
    src_diff = {1'b0, wp} - ((AW + 1)'(cpy_dist) + (AW + 1)'(1));
    src_addr = src_diff[AW] ? AW'(src_diff + (AW + 1)'(HISTORY_DEPTH)) : src_diff[AW-1:0];
  end

  // results
  always_comb begin
    out_load      = 1'b0;
    out_word_next = '0;
    out_cnt_next  = '0;
    out_last_next = 1'b1;
    out_err_next  = 1'b0;
    if (cmd.decode && lit_write) begin
      out_load      = 1'b1;
      out_word_next = WORD_W'(hold_byte);
      out_cnt_next  = CNT_W'(1);
    end else if (cmd.decode && ps_eff == PS_DISTANCE && ref_err) begin
      out_load     = 1'b1;
      out_err_next = 1'b1;
    end else if (cmd.emit) begin
      out_load      = 1'b1;
      out_word_next = lane_word;
      out_cnt_next  = lane_cnt;
      out_last_next = (cpy_left == '0);
    end
  end

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.copy_go   = (ps_eff == PS_DISTANCE) && !ref_err;
  assign stat.lane_done = (lane_cnt == CNT_W'(OUT_LANES - 1)) || (cpy_left == LEN_W'(1));
  assign stat.copy_end  = (cpy_left == '0);

  always_ff @(posedge clk) begin
    if (append) begin
      hist[wp] <= wr_byte;
    end
    if (cmd.rd) begin
      rd_data <= hist[src_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps        <= PS_START;
      lit_rem   <= '0;
      lit_total <= '0;
      mlen      <= '0;
      mdist     <= '0;
      produced  <= '0;
      wp        <= '0;
      cpy_left  <= '0;
      lane_cnt  <= '0;
      lane_word <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decode) begin
        ps        <= ps_next;
        lit_rem   <= lit_rem_next;
        lit_total <= lit_total_next;
        mlen      <= mlen_next;
        mdist     <= mdist_next;
        if (stat.copy_go) begin
          cpy_left  <= mlen_eff;
          cpy_dist  <= dist_full;
          lane_cnt  <= '0;
          lane_word <= '0;
        end
      end
      produced <= produced_next;
      if (append) begin
        wp <= wp_inc;
      end
      if (cmd.wr) begin
        lane_word[8*lane_cnt[LANE_W-1:0] +: 8] <= rd_data;
        lane_cnt <= lane_cnt + CNT_W'(1);
        cpy_left <= cpy_left - LEN_W'(1);
      end
      if (cmd.emit) begin
        lane_cnt  <= '0;
        lane_word <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hold_byte  <= in_byte;
      hold_start <= stream_start;
    end
    if (out_load) begin
      out_bytes  <= out_word_next;
      byte_count <= out_cnt_next;
      last       <= out_last_next;
      error      <= out_err_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> stat.out_free)
    else $error("result loaded over a waiting result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count <= CNT_W'(OUT_LANES))
    else $error("byte_count exceeds lane count");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (byte_count == '0 && last))
    else $error("error result carries bytes");

  a_lane_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> lane_cnt < CNT_W'(OUT_LANES))
    else $error("lane word overfilled");

endmodule

// ===== hdl/lzf_decompressor.sv =====
// Top level of the LZF decompressor: controller plus datapath.
// Depends on lzfd_pkg, lzfd_ctrl and lzfd_datapath.
//
//   channel | signals                                       | handshake
//   input   | in_byte, stream_start                         | in_valid / in_ready
//   output  | out_bytes, byte_count, last, error            | out_valid / out_ready
//
// Steps: each input byte is accepted in idle, then decoded once the output register is
//   free; a literal or an error result is loaded into that register at decode.
// A back reference of length L is copied byte by byte (history read, then append),
//   with one emit per result word, ceil(L/OUT_LANES) words in all.
// The single-port history read with registered data sets the copy rate.
// Reset clears parse state, counters and output valid; history is not cleared.
// A waiting result stalls decode and emit; input is taken again only in idle.
module lzf_decompressor
  import lzfd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int OUT_LANES     = OUT_LANES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              stream_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_bytes,
  output logic [CNT_W-1:0]  byte_count,
  output logic              last,
  output logic              error
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence each item: capture, decode, then copy loop when a reference resolves
  lzfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold parse registers, history memory and the output register
  lzfd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .OUT_LANES     (OUT_LANES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_byte      (in_byte),
    .stream_start (stream_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bytes    (out_bytes),
    .byte_count   (byte_count),
    .last         (last),
    .error        (error)
  );

endmodule
